// File: hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the LCD nibble command queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed: condition must never hold");
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication violated");
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication violated");
`else
`define ASSERT_NEVER(lbl, cond)
`define ASSERT_IMPLIES(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: hw/rtl/lncq_pkg.sv
// Types and constants shared by the LCD nibble command queue modules.
package lncq_pkg;

  localparam int TICK_RATE_W  = 14;
  localparam int ADDR_W       = 7;
  localparam int CFG_INDEX_W  = 4;
  localparam int CFG_DATA_W   = 14;
  localparam int TICKS_W      = 12;
  localparam int PROD_W       = 22;
  localparam int RECIP_PROD_W = 45;
  localparam int QUOT_W       = 13;
  localparam int RECIP_SHIFT  = 32;
  localparam int COUNTER_W    = 32;
  localparam int MAX_RESULTS  = 16;
  localparam int BURST_W      = $clog2(MAX_RESULTS);

  localparam logic [CFG_INDEX_W-1:0] REG_TICK_RATE      = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_ADDRESS = 4'd1;

  localparam logic [1:0] REQ_COMMAND = 2'd0;
  localparam logic [1:0] REQ_DATA    = 2'd1;
  localparam logic [1:0] REQ_TICK    = 2'd2;

  localparam logic [TICK_RATE_W-1:0] TICK_RATE_RESET = 14'd1000;
  localparam logic [ADDR_W-1:0]      DEVICE_ADDR_RESET = 7'd39;

  // ceil(2^32 / 1000); exact floor division for products below 2^22.
  localparam logic [RECIP_PROD_W-1:0] RECIP_1000 = 45'd4294968;
  localparam logic [QUOT_W-1:0]       DELAY_MAX  = 13'd4095;

  localparam logic [7:0] HI_MASK     = 8'hF0;
  localparam logic [7:0] CMD_EN      = 8'h0C;
  localparam logic [7:0] CMD_DIS     = 8'h08;
  localparam logic [7:0] DATA_EN     = 8'h0D;
  localparam logic [7:0] DATA_DIS    = 8'h09;

  typedef struct packed {
    logic [7:0]         value;
    logic               is_data;
    logic [TICKS_W-1:0] ticks;
  } entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } chain_ctl_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage

// File: hw/rtl/lncq_cell.sv
// One queue cell: holds an entry, loads a new one or takes its neighbor's.
module lncq_cell (
  input  logic                clk,
  input  lncq_pkg::cell_ctl_t ctl,
  input  lncq_pkg::entry_t    load_entry,
  input  lncq_pkg::entry_t    next_entry,
  output lncq_pkg::entry_t    entry
);

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      entry <= next_entry;
    end else if (ctl.load) begin
      entry <= load_entry;
    end
  end

endmodule

// File: hw/rtl/lncq_chain.sv
// Row of queue cells; the head sits in cell zero and pops shift toward it.
module lncq_chain #(
  parameter int DEPTH = 16,
  localparam int IDX_W = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  lncq_pkg::chain_ctl_t ctl,
  input  logic [IDX_W-1:0]     wr_index,
  input  lncq_pkg::entry_t     wr_entry,
  output lncq_pkg::entry_t     head
);

  lncq_pkg::entry_t cells [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    lncq_pkg::cell_ctl_t cctl;
    lncq_pkg::entry_t    nbr;

    assign cctl.load  = ctl.push && (wr_index == IDX_W'(i));
    assign cctl.shift = ctl.pop;

    if (i == DEPTH - 1) begin : g_tail
      assign nbr = '0;
    end else begin : g_inner
      assign nbr = cells[i+1];
    end

    lncq_cell u_cell (
      .clk        (clk),
      .ctl        (cctl),
      .load_entry (wr_entry),
      .next_entry (nbr),
      .entry      (cells[i])
    );
  end

  assign head = cells[0];

endmodule

// File: hw/rtl/lcd_nibble_command_queue_top.sv
// Top level of the paced LCD nibble command queue with its control sequencer.
// Enqueue: the status word leaves via the recip and push states (the full state when full); words are taken in idle.
// Tick: bus frames leave from the burst state, one per cycle while the output is free, up to 16,
// ending early at a nonzero delay or an empty queue; a stalled output holds the word in work.
// Reset clears counters, queue fill and output valid, and restores registers;
// queue cell contents stay undefined until written.
`include "assert_macros.svh"

module lcd_nibble_command_queue_top #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // byte_value[7:0], delay_ms[15:8]
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // enqueue_status[0], target_address[7:1],
                                 // frame_byte0[15:8], frame_byte1[23:16],
                                 // frame_byte2[31:24], frame_byte3[39:32]
  output logic        m_tuser,   // result_kind[0]
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [lncq_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lncq_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {ST_IDLE, ST_RECIP, ST_PUSH, ST_FULL, ST_BURST} state_t;

  state_t state;
  logic [lncq_pkg::TICK_RATE_W-1:0]  tick_rate_hz;
  logic [lncq_pkg::ADDR_W-1:0]       device_address;
  logic [CNT_W-1:0]                  count;
  logic [lncq_pkg::COUNTER_W-1:0]    tick_counter;
  logic [lncq_pkg::COUNTER_W-1:0]    cooldown_until;
  logic [lncq_pkg::BURST_W-1:0]      burst_count;
  logic [7:0]                        req_byte;
  logic                              req_is_data;
  logic [lncq_pkg::PROD_W-1:0]       prod;
  logic [lncq_pkg::RECIP_PROD_W-1:0] recip_prod;

  logic                             out_free;
  logic                             out_load;
  logic                             s_accept;
  logic [lncq_pkg::COUNTER_W-1:0]   tick_counter_next;
  logic [lncq_pkg::QUOT_W-1:0]      quot;
  logic [lncq_pkg::TICKS_W-1:0]     ticks_sat;
  logic                             burst_end;
  logic [7:0]                       hi_nib;
  logic [7:0]                       lo_nib;
  logic [7:0]                       en_bits;
  logic [7:0]                       dis_bits;
  lncq_pkg::chain_ctl_t             cctl;
  lncq_pkg::entry_t                 wr_entry;
  lncq_pkg::entry_t                 head;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign s_accept  = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign out_load  = (state inside {ST_PUSH, ST_FULL, ST_BURST}) && out_free;

  assign tick_counter_next = tick_counter + 1'b1;
  assign quot = recip_prod[lncq_pkg::RECIP_SHIFT +: lncq_pkg::QUOT_W];
  assign ticks_sat = (quot > lncq_pkg::DELAY_MAX) ? lncq_pkg::DELAY_MAX[lncq_pkg::TICKS_W-1:0]
                                                  : quot[lncq_pkg::TICKS_W-1:0];

  assign wr_entry.value   = req_byte;
  assign wr_entry.is_data = req_is_data;
  assign wr_entry.ticks   = req_is_data ? '0 : ticks_sat;

  assign cctl.push = (state == ST_PUSH) && out_free;
  assign cctl.pop  = (state == ST_BURST) && out_free;

  assign burst_end = (head.ticks != '0) || (count == CNT_W'(1)) ||
                     (burst_count == lncq_pkg::BURST_W'(lncq_pkg::MAX_RESULTS - 1));

  assign hi_nib   = head.value & lncq_pkg::HI_MASK;
  assign lo_nib   = {head.value[3:0], 4'h0};
  assign en_bits  = head.is_data ? lncq_pkg::DATA_EN : lncq_pkg::CMD_EN;
  assign dis_bits = head.is_data ? lncq_pkg::DATA_DIS : lncq_pkg::CMD_DIS;

  lncq_chain #(.DEPTH(QUEUE_DEPTH)) u_chain (
    .clk      (clk),
    .ctl      (cctl),
    .wr_index (count[IDX_W-1:0]),
    .wr_entry (wr_entry),
    .head     (head)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      tick_rate_hz   <= lncq_pkg::TICK_RATE_RESET;
      device_address <= lncq_pkg::DEVICE_ADDR_RESET;
      count          <= '0;
      tick_counter   <= '0;
      cooldown_until <= '0;
      burst_count    <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lncq_pkg::REG_TICK_RATE:      tick_rate_hz <= cfg_data;
          lncq_pkg::REG_DEVICE_ADDRESS: device_address <= cfg_data[lncq_pkg::ADDR_W-1:0];
          default: ;
        endcase
      end

      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (s_accept) begin
            req_byte    <= s_tdata[7:0];
            req_is_data <= (s_tuser == lncq_pkg::REQ_DATA);
            prod <= lncq_pkg::PROD_W'(s_tdata[15:8]) * lncq_pkg::PROD_W'(tick_rate_hz);
            case (s_tuser)
              lncq_pkg::REQ_COMMAND, lncq_pkg::REQ_DATA: begin
                state <= (count == CNT_W'(QUEUE_DEPTH)) ? ST_FULL : ST_RECIP;
              end
              lncq_pkg::REQ_TICK: begin
                tick_counter <= tick_counter_next;
                burst_count  <= '0;
                if ((count != '0) && (tick_counter_next > cooldown_until)) begin
                  state <= ST_BURST;
                end
              end
              default: ;
            endcase
          end
        end
        ST_RECIP: begin
          recip_prod <= lncq_pkg::RECIP_PROD_W'(prod) * lncq_pkg::RECIP_1000;
          state      <= ST_PUSH;
        end
        ST_PUSH, ST_FULL: begin
          if (out_free) begin
            m_tuser  <= 1'b0;
            m_tlast  <= 1'b1;
            m_tdata  <= {39'd0, (state == ST_FULL)};
            if (state == ST_PUSH) begin
              count <= count + 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        ST_BURST: begin
          if (out_free) begin
            m_tuser  <= 1'b1;
            m_tlast  <= burst_end;
            m_tdata  <= {lo_nib | dis_bits, lo_nib | en_bits,
                         hi_nib | dis_bits, hi_nib | en_bits, device_address, 1'b0};
            count       <= count - 1'b1;
            burst_count <= burst_count + 1'b1;
            if (burst_end) begin
              cooldown_until <= tick_counter + lncq_pkg::COUNTER_W'(head.ticks);
              state          <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_NEVER(a_push_pop_overlap, cctl.push && cctl.pop)
  `ASSERT_NEVER(a_count_overflow, count > CNT_W'(QUEUE_DEPTH))
  `ASSERT_IMPLIES(a_pop_nonempty, cctl.pop, count != '0)
  `ASSERT_NEXT(a_push_counts, cctl.push, count == ($past(count) + 1'b1))

endmodule

// File: test/lcd_nibble_command_queue_top_test.sv
// Self-checking testbench for the LCD nibble command queue top level.
`timescale 1ns / 100ps

module lcd_nibble_command_queue_top_test;

  localparam int QUEUE_DEPTH  = 16;
  localparam int LIMIT_CYCLES = 600000;
  localparam int REPORT_MAX   = 10;
  localparam int SETTLE       = 12;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [lncq_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 4'd15;

  typedef struct packed {
    logic       kind;
    logic       status;
    logic [6:0] addr;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic       is_last;
  } lcd_word_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [lncq_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [lncq_pkg::CFG_DATA_W-1:0]  cfg_data;

  // Copy of the block state used to work out the expected words.
  lncq_pkg::entry_t    q_store [QUEUE_DEPTH];
  logic [3:0]          q_rd;
  logic [3:0]          q_wr;
  int unsigned         q_fill;
  logic [31:0]         tick_count;
  logic [31:0]         cooldown_mark;
  logic [13:0]         rate_q;
  logic [6:0]          addr_q;

  lcd_word_t expected_words [$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned sender_idle_pct;
  int unsigned stall_pct;
  int unsigned hold_request;
  int unsigned hold_left;

  lcd_nibble_command_queue_top #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  function automatic void push_word(logic kind, logic status, logic [6:0] addr,
                                    logic [31:0] frame, logic is_last);
    lcd_word_t w;
    w.kind = kind;
    w.status = status;
    w.addr = addr;
    w.b0 = frame[7:0];
    w.b1 = frame[15:8];
    w.b2 = frame[23:16];
    w.b3 = frame[31:24];
    w.is_last = is_last;
    expected_words.push_back(w);
  endfunction

  function automatic void model_config(logic [lncq_pkg::CFG_INDEX_W-1:0] idx,
                                       logic [13:0] val);
    if (idx == lncq_pkg::REG_TICK_RATE) begin
      rate_q = val;
    end else if (idx == lncq_pkg::REG_DEVICE_ADDRESS) begin
      addr_q = val[6:0];
    end
  endfunction

  function automatic void model_lcd_request(logic [1:0] req, logic [7:0] val,
                                            logic [7:0] dms);
    logic [31:0] prod;
    logic [31:0] ticks;
    logic [11:0] sent_ticks;
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [7:0]  en;
    logic [7:0]  dis;
    lncq_pkg::entry_t e;
    int          n;
    logic        ends;
    n = 0;
    case (req)
      lncq_pkg::REQ_COMMAND, lncq_pkg::REQ_DATA: begin
        if (q_fill >= QUEUE_DEPTH) begin
          push_word(1'b0, 1'b1, 7'd0, 32'd0, 1'b1);
        end else begin
          prod = {24'd0, dms} * {18'd0, rate_q};
          ticks = (req == lncq_pkg::REQ_COMMAND) ? prod / 1000 : 32'd0;
          if (ticks > 32'd4095) ticks = 32'd4095;
          q_store[q_wr] = '{value: val, is_data: (req == lncq_pkg::REQ_DATA),
                            ticks: ticks[11:0]};
          q_wr = q_wr + 4'd1;
          q_fill++;
          push_word(1'b0, 1'b0, 7'd0, 32'd0, 1'b1);
        end
      end
      lncq_pkg::REQ_TICK: begin
        tick_count = tick_count + 32'd1;
        if (q_fill != 0 && tick_count > cooldown_mark) begin
          sent_ticks = '0;
          ends = 1'b0;
          while (!ends) begin
            e = q_store[q_rd];
            hi = e.value & lncq_pkg::HI_MASK;
            lo = {e.value[3:0], 4'h0};
            en = e.is_data ? lncq_pkg::DATA_EN : lncq_pkg::CMD_EN;
            dis = e.is_data ? lncq_pkg::DATA_DIS : lncq_pkg::CMD_DIS;
            n++;
            sent_ticks = e.ticks;
            q_rd = q_rd + 4'd1;
            q_fill--;
            ends = (q_fill == 0) || (n >= lncq_pkg::MAX_RESULTS) || (sent_ticks != 0);
            push_word(1'b1, 1'b0, addr_q, {lo | dis, lo | en, hi | dis, hi | en}, ends);
          end
          cooldown_mark = tick_count + {20'd0, sent_ticks};
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void note_mismatch(string field, longint want, longint got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX)
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
  endfunction

  always @(posedge clk) begin
    lcd_word_t got;
    lcd_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.kind = m_tuser;
      got.status = m_tdata[0];
      got.addr = m_tdata[7:1];
      got.b0 = m_tdata[15:8];
      got.b1 = m_tdata[23:16];
      got.b2 = m_tdata[31:24];
      got.b3 = m_tdata[39:32];
      got.is_last = m_tlast;
      if (expected_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("%0t: unexpected word 0x%0h", $time, got);
      end else begin
        want = expected_words.pop_front();
        if (got.kind !== want.kind) note_mismatch("result_kind", want.kind, got.kind);
        if (got.status !== want.status) note_mismatch("enqueue_status", want.status, got.status);
        if (got.addr !== want.addr) note_mismatch("target_address", want.addr, got.addr);
        if (got.b0 !== want.b0) note_mismatch("frame_byte0", want.b0, got.b0);
        if (got.b1 !== want.b1) note_mismatch("frame_byte1", want.b1, got.b1);
        if (got.b2 !== want.b2) note_mismatch("frame_byte2", want.b2, got.b2);
        if (got.b3 !== want.b3) note_mismatch("frame_byte3", want.b3, got.b3);
        if (got.is_last !== want.is_last) note_mismatch("last_of_burst", want.is_last, got.is_last);
      end
    end
  end

  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_request(input logic [1:0] req, input logic [7:0] val,
                              input logic [7:0] dms);
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tuser <= req;
    s_tdata <= {dms, val};
    do @(posedge clk); while (!s_tready);
    model_lcd_request(req, val, dms);
    gap = 0;
    if ($urandom_range(99) < sender_idle_pct) gap = $urandom_range(1, 4);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random_request();
    int unsigned pick;
    int unsigned cap;
    logic [7:0]  dms;
    pick = $urandom_range(99);
    cap = (rate_q <= 78) ? 255 : 20000 / rate_q;
    dms = ($urandom_range(99) < 40) ? 8'd0 : 8'($urandom_range(0, cap));
    if (pick < 3)
      send_request(REQ_UNUSED, 8'($urandom), 8'($urandom));
    else if (pick < 38)
      send_request(lncq_pkg::REQ_TICK, 8'($urandom), 8'($urandom));
    else if (pick < 69)
      send_request(lncq_pkg::REQ_COMMAND, 8'($urandom), dms);
    else
      send_request(lncq_pkg::REQ_DATA, 8'($urandom), 8'($urandom));
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_register(input logic [lncq_pkg::CFG_INDEX_W-1:0] idx,
                                input logic [13:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    model_config(idx, val);
  endtask

  task automatic apply_settings(input logic [13:0] rate, input logic [13:0] addr_word);
    wait_drain();
    write_register(lncq_pkg::REG_TICK_RATE, rate);
    write_register(lncq_pkg::REG_DEVICE_ADDRESS, addr_word);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_queue_full_burst();
    logic [7:0] pattern [4];
    pattern = '{8'h00, 8'hFF, 8'hA5, 8'h5A};
    sender_idle_pct = 0;
    stall_pct = 0;
    for (int i = 0; i < QUEUE_DEPTH; i++)
      send_request(i[0] ? lncq_pkg::REQ_DATA : lncq_pkg::REQ_COMMAND,
                   (i < 4) ? pattern[i] : 8'($urandom), 8'd0);
    send_request(lncq_pkg::REQ_COMMAND, 8'h12, 8'd1);
    send_request(lncq_pkg::REQ_TICK, 8'h00, 8'h00);
    wait_drain();
  endtask

  task automatic test_delay_rules();
    send_request(lncq_pkg::REQ_TICK, 8'hFF, 8'hFF);
    send_request(lncq_pkg::REQ_COMMAND, 8'h3C, 8'd2);
    send_request(lncq_pkg::REQ_DATA, 8'hC3, 8'd255);
    send_request(lncq_pkg::REQ_TICK, 8'h00, 8'h00);
    send_request(lncq_pkg::REQ_TICK, 8'h00, 8'h00);
    send_request(lncq_pkg::REQ_TICK, 8'h00, 8'h00);
    send_request(REQ_UNUSED, 8'hFF, 8'hFF);
    send_request(lncq_pkg::REQ_TICK, 8'h00, 8'h00);
    wait_drain();
  endtask

  task automatic test_delay_saturation();
    apply_settings(14'h3FFF, 14'd127);
    send_request(lncq_pkg::REQ_TICK, 8'h00, 8'h00);
    send_request(lncq_pkg::REQ_COMMAND, 8'h80, 8'd255);
    send_request(lncq_pkg::REQ_DATA, 8'h7F, 8'd0);
    send_request(lncq_pkg::REQ_TICK, 8'h00, 8'h00);
    for (int i = 0; i < 4; i++) send_request(lncq_pkg::REQ_TICK, 8'h00, 8'h00);
    wait_drain();
  endtask

  task automatic test_zero_tick_rate();
    wait_drain();
    write_register(lncq_pkg::REG_TICK_RATE, 14'd0);
    write_register(lncq_pkg::REG_DEVICE_ADDRESS, 14'd0);
    write_register(REG_UNUSED, 14'h3FFF);
    cfg_valid <= 1'b0;
    send_request(lncq_pkg::REQ_COMMAND, 8'hFF, 8'd255);
    send_request(lncq_pkg::REQ_COMMAND, 8'h01, 8'd255);
    send_request(lncq_pkg::REQ_TICK, 8'h00, 8'h00);
    wait_drain();
  endtask

  task automatic test_backpressure();
    apply_settings(lncq_pkg::TICK_RATE_RESET, 14'(lncq_pkg::DEVICE_ADDR_RESET));
    sender_idle_pct = 0;
    stall_pct = 0;
    hold_request = 300;
    for (int i = 0; i < 40; i++) send_random_request();
    wait_drain();
    for (int i = 0; i < 20; i++) begin
      send_random_request();
      wait_drain();
    end
  endtask

  task automatic test_random_phase(input int unsigned count, input int unsigned idle,
                                   input int unsigned stall, input logic [13:0] rate,
                                   input logic [13:0] addr_word);
    apply_settings(rate, addr_word);
    sender_idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < count; i++) send_random_request();
    wait_drain();
  endtask

  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    m_tready <= 1'b0;
    mismatch_count = 0;
    cycle_count = 0;
    sender_idle_pct = 0;
    stall_pct = 0;
    hold_request = 0;
    hold_left = 0;
    q_rd = '0;
    q_wr = '0;
    q_fill = 0;
    tick_count = '0;
    cooldown_mark = '0;
    rate_q = lncq_pkg::TICK_RATE_RESET;
    addr_q = lncq_pkg::DEVICE_ADDR_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_queue_full_burst();
    test_delay_rules();
    test_zero_tick_rate();
    test_backpressure();
    test_random_phase(55, 0, 0, 14'd1000, 14'd39);
    test_random_phase(55, 49, 0, 14'd1, 14'd0);
    test_random_phase(55, 0, 49, 14'd10000, 14'd127);
    test_random_phase(55, 11, 11, 14'($urandom_range(1, 10000)), 14'($urandom));
    test_random_phase(55, 11, 11, 14'd250, 14'h2055);
    test_random_phase(55, 0, 0, 14'd0, 14'($urandom));
    test_delay_saturation();

    mismatch_count += expected_words.size();
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
